FILE: design/isa_pkg.sv
`default_nettype none

package isa_pkg;

    // Field widths of the request and response payloads.
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 7;
    localparam int IDX2_W  = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IDX_W-1:0]   index;
        logic [IDX2_W-1:0]  index_b;
        logic [VALUE_W-1:0] value;
    } isa_req_t;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_data;
        logic [COUNT_W-1:0] count;
    } isa_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GET_RD,
        ST_UP_RD,
        ST_UP_WR,
        ST_DN_RD,
        ST_DN_WR,
        ST_WR_VAL,
        ST_SW_RD_A,
        ST_SW_RD_B,
        ST_SW_WR_A,
        ST_SW_WR_B,
        ST_FINISH
    } isa_state_t;

    typedef enum logic [2:0] {
        ADDR_PTR,
        ADDR_PTR_DEC,
        ADDR_PTR_INC,
        ADDR_IDX,
        ADDR_IDX2
    } isa_addr_sel_t;

    typedef enum logic [1:0] {
        WD_RDATA,
        WD_VALUE,
        WD_SAVED
    } isa_wd_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_CNT,
        PTR_LOAD_IDX,
        PTR_INC,
        PTR_DEC
    } isa_ptr_op_t;

    // Controller to datapath.
    typedef struct packed {
        logic          req_load;
        logic          mem_rd;
        logic          mem_wr;
        isa_addr_sel_t addr_sel;
        isa_wd_sel_t   wd_sel;
        isa_ptr_op_t   ptr_op;
        logic          save_a;
        logic          finish;
    } isa_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             ok;
        logic             ptr_at_idx;
        logic             shift_done;
        logic             out_free;
    } isa_status_t;

endpackage

`default_nettype wire

FILE: design/isa_ctrl.sv
`default_nettype none

module isa_ctrl
    import isa_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  isa_status_t status_i,
    output isa_cmd_t    cmd_o
);

    isa_state_t state_reg;
    isa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status_i.ok) begin
                    state_next = ST_FINISH;
                end else begin
                    case (status_i.command)
                        CMD_GET:    state_next = ST_GET_RD;
                        CMD_INSERT: state_next = ST_UP_RD;
                        CMD_DELETE: state_next = ST_DN_RD;
                        CMD_PUSH:   state_next = ST_WR_VAL;
                        CMD_SWAP:   state_next = ST_SW_RD_A;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_GET_RD:  state_next = ST_FINISH;
            ST_UP_RD: begin
                state_next = status_i.ptr_at_idx ? ST_WR_VAL : ST_UP_WR;
            end
            ST_UP_WR:   state_next = ST_UP_RD;
            ST_DN_RD: begin
                state_next = status_i.shift_done ? ST_FINISH : ST_DN_WR;
            end
            ST_DN_WR:   state_next = ST_DN_RD;
            ST_WR_VAL:  state_next = ST_FINISH;
            ST_SW_RD_A: state_next = ST_SW_RD_B;
            ST_SW_RD_B: state_next = ST_SW_WR_A;
            ST_SW_WR_A: state_next = ST_SW_WR_B;
            ST_SW_WR_B: state_next = ST_FINISH;
            ST_FINISH: begin
                if (status_i.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd_o.req_load = 1'b0;
        cmd_o.mem_rd   = 1'b0;
        cmd_o.mem_wr   = 1'b0;
        cmd_o.addr_sel = ADDR_PTR;
        cmd_o.wd_sel   = WD_RDATA;
        cmd_o.ptr_op   = PTR_HOLD;
        cmd_o.save_a   = 1'b0;
        cmd_o.finish   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd_o.req_load = s_valid;
            end
            ST_DECODE: begin
                // Delete walks up from the index; insert and push start at the end.
                cmd_o.ptr_op = (status_i.command == CMD_DELETE) ? PTR_LOAD_IDX
                                                                : PTR_LOAD_CNT;
            end
            ST_GET_RD: begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.addr_sel = ADDR_IDX;
            end
            ST_UP_RD: begin
                cmd_o.mem_rd   = !status_i.ptr_at_idx;
                cmd_o.addr_sel = ADDR_PTR_DEC;
            end
            ST_UP_WR: begin
                cmd_o.mem_wr = 1'b1;
                cmd_o.ptr_op = PTR_DEC;
            end
            ST_DN_RD: begin
                cmd_o.mem_rd   = !status_i.shift_done;
                cmd_o.addr_sel = ADDR_PTR_INC;
            end
            ST_DN_WR: begin
                cmd_o.mem_wr = 1'b1;
                cmd_o.ptr_op = PTR_INC;
            end
            ST_WR_VAL: begin
                cmd_o.mem_wr = 1'b1;
                cmd_o.wd_sel = WD_VALUE;
            end
            ST_SW_RD_A: begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.addr_sel = ADDR_IDX;
            end
            ST_SW_RD_B: begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.addr_sel = ADDR_IDX2;
                cmd_o.save_a   = 1'b1;
            end
            ST_SW_WR_A: begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.addr_sel = ADDR_IDX;
            end
            ST_SW_WR_B: begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.addr_sel = ADDR_IDX2;
                cmd_o.wd_sel   = WD_SAVED;
            end
            ST_FINISH: begin
                cmd_o.finish = status_i.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/isa_dp.sv
`default_nettype none

module isa_dp
    import isa_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  isa_req_t    s_payload,
    input  isa_cmd_t    cmd_i,
    output isa_status_t status_o,
    input  wire         m_ready,
    output logic        m_valid,
    output isa_rsp_t    m_payload
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int WORD_W = (ITEM_BITS > VALUE_W) ? ITEM_BITS : VALUE_W;

    logic [ITEM_BITS-1:0] mem [CAPACITY];

    isa_req_t             req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     ptr_next;
    logic [ITEM_BITS-1:0] rdata_reg;
    logic [ITEM_BITS-1:0] saved_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    isa_rsp_t             m_payload_reg;
    isa_rsp_t             m_payload_next;

    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     idx2_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     ptr_ext;
    logic [CMP_W-1:0]     cnt_new_ext;
    logic [CNT_W-1:0]     ptr_inc;
    logic [CNT_W-1:0]     ptr_dec;
    logic [CNT_W:0]       ptr_plus;
    logic                 op_ok;
    logic                 not_full;
    logic                 not_empty;
    logic [ADDR_W-1:0]    mem_addr;
    logic [ITEM_BITS-1:0] mem_wdata;
    logic [WORD_W-1:0]    value_ext;
    logic [WORD_W-1:0]    rd_ext;

    assign idx_ext   = CMP_W'(req_reg.index);
    assign idx2_ext  = CMP_W'(req_reg.index_b);
    assign cnt_ext   = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(CAPACITY);
    assign ptr_ext   = CMP_W'(ptr_reg);
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign ptr_plus  = {1'b0, ptr_reg} + (CNT_W + 1)'(1);
    assign not_full  = cnt_ext < cap_ext;
    assign not_empty = count_reg != '0;
    assign value_ext = WORD_W'(req_reg.value);
    assign rd_ext    = WORD_W'(rdata_reg);

    always_comb begin
        case (req_reg.command)
            CMD_GET:    op_ok = idx_ext < cnt_ext;
            CMD_INSERT: op_ok = (idx_ext <= cnt_ext) && not_full;
            CMD_DELETE: op_ok = idx_ext < cnt_ext;
            CMD_PUSH:   op_ok = not_full;
            CMD_POP:    op_ok = not_empty;
            CMD_SWAP:   op_ok = (idx_ext < cnt_ext) && (idx2_ext < cnt_ext);
            default:    op_ok = 1'b0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (op_ok) begin
            case (req_reg.command)
                CMD_INSERT: count_next = count_reg + CNT_W'(1);
                CMD_PUSH:   count_next = count_reg + CNT_W'(1);
                CMD_DELETE: count_next = count_reg - CNT_W'(1);
                CMD_POP:    count_next = count_reg - CNT_W'(1);
                default:    count_next = count_reg;
            endcase
        end
    end

    assign status_o.command    = req_reg.command;
    assign status_o.ok         = op_ok;
    assign status_o.ptr_at_idx = ptr_ext == idx_ext;
    assign status_o.shift_done = ptr_plus >= {1'b0, count_reg};
    assign status_o.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd_i.addr_sel)
            ADDR_PTR:     mem_addr = ptr_reg[ADDR_W-1:0];
            ADDR_PTR_DEC: mem_addr = ptr_dec[ADDR_W-1:0];
            ADDR_PTR_INC: mem_addr = ptr_inc[ADDR_W-1:0];
            ADDR_IDX:     mem_addr = idx_ext[ADDR_W-1:0];
            ADDR_IDX2:    mem_addr = idx2_ext[ADDR_W-1:0];
            default:      mem_addr = ptr_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        case (cmd_i.wd_sel)
            WD_RDATA: mem_wdata = rdata_reg;
            WD_VALUE: mem_wdata = value_ext[ITEM_BITS-1:0];
            WD_SAVED: mem_wdata = saved_reg;
            default:  mem_wdata = rdata_reg;
        endcase
    end

    always_comb begin
        case (cmd_i.ptr_op)
            PTR_HOLD:     ptr_next = ptr_reg;
            PTR_LOAD_CNT: ptr_next = count_reg;
            PTR_LOAD_IDX: ptr_next = idx_ext[CNT_W-1:0];
            PTR_INC:      ptr_next = ptr_inc;
            PTR_DEC:      ptr_next = ptr_dec;
            default:      ptr_next = ptr_reg;
        endcase
    end

    // Only a successful get returns the word in the read register; every other response reads zero.
    assign cnt_new_ext              = CMP_W'(count_next);
    assign m_payload_next.ok        = op_ok;
    assign m_payload_next.read_data = (req_reg.command == CMD_GET && op_ok)
                                      ? rd_ext[VALUE_W-1:0] : '0;
    assign m_payload_next.count     = cnt_new_ext[COUNT_W-1:0];

    always_comb begin
        if (cmd_i.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.mem_wr) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd_i.mem_rd) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.req_load) begin
            req_reg <= s_payload;
        end
        if (cmd_i.save_a) begin
            saved_reg <= rdata_reg;
        end
        if (cmd_i.finish) begin
            m_payload_reg <= m_payload_next;
        end
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd_i.finish) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_ext <= cap_ext)
        else $error("fill count exceeds capacity");

    a_count_only_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd_i.finish |=> $stable(count_reg))
        else $error("fill count changed outside finish");

    a_one_mem_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd_i.mem_rd && cmd_i.mem_wr))
        else $error("memory read and write in the same cycle");

    a_finish_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.finish |-> status_o.out_free)
        else $error("response overwritten before it was taken");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd_i.finish))
        else $error("response valid raised without a finished request");

endmodule

`default_nettype wire

FILE: design/indexed_shift_array.sv
// Ordered array of words with a fill count, driven by one request at a time.
// The s_ channel carries a request (get, insert, delete, push, pop or swap);
// the m_ channel returns exactly one response per request with a success
// flag, the word read by a successful get (zero otherwise) and the new count.
// Both channels use valid/ready and move a request when both are high.
// The entries live in a single-port memory with a registered read, so every
// entry move takes a read of the memory and then a write.
// Insert and delete move the entries over the memory port one at a time,
// so they take longer the more entries lie above the index. A new request
// can be taken in the cycle after the previous response is loaded into the
// output register, so requests never overlap in the controller.
// Reset clears the fill count and the response valid flag; the entry memory
// is not cleared, since no entry below the count is ever unwritten.
// The response is held in an output register; a new request may be accepted
// while it waits, but that request's response waits in its final state
// until the receiver takes the previous one.

`default_nettype none

module indexed_shift_array
    import isa_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 32
) (
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_valid,
    output logic     s_ready,
    input  isa_req_t s_payload,
    output logic     m_valid,
    input  wire      m_ready,
    output isa_rsp_t m_payload
);

    isa_cmd_t    cmd;
    isa_status_t status;

    // The controller sequences each request through the memory port.
    isa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    // The datapath holds the memory, the count, the walk pointer and the
    // response register.
    isa_dp #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd_i     (cmd),
        .status_o  (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire
